// ===== sv/iisk_pkg.sv =====
// Shared constants and types for the indirect insertion sort block.
package iisk_pkg;

  // Capacity and derived widths
  localparam int MAX_RECORDS = 64;
  localparam int ADDR_W      = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  // Field widths
  localparam int PHONE_W = 21;
  localparam int AGE_W   = 7;
  localparam int KEY_W   = PHONE_W + AGE_W;
  localparam int OIDX_W  = 6;

  // Key order codes
  localparam logic MODE_AGE_PHONE = 1'b0;
  localparam logic MODE_PHONE_AGE = 1'b1;

  // One sorter slot
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [OIDX_W-1:0] idx;
  } slot_t;

  // Per-cycle command to the cell row
  typedef struct packed {
    logic insert;
    logic shift;
  } chain_ctrl_t;

  // Build a comparable key from a stored {phone, age} record
  function automatic logic [KEY_W-1:0] sort_key(input logic mode,
                                                input logic [KEY_W-1:0] rec);
    logic [PHONE_W-1:0] phone;
    logic [AGE_W-1:0]   age;
    phone = rec[KEY_W-1:AGE_W];
    age   = rec[AGE_W-1:0];
    if (mode == MODE_PHONE_AGE) begin
      sort_key = {phone, age};
    end else begin
      sort_key = {age, phone};
    end
  endfunction

endpackage

// ===== sv/iisk_ram.sv =====
// Generic single-port-write, registered-read RAM.
module iisk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/iisk_cell.sv =====
// One insertion cell: holds a slot, inserts, shifts right on insert, left on drain.
module iisk_cell
  import iisk_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  chain_ctrl_t      ctrl,
  input  slot_t            new_slot,
  input  slot_t            prev_slot,
  input  logic             prev_gt,
  input  slot_t            next_slot,
  output slot_t            slot,
  output logic             gt
);

  // Slot goes after the new entry: empty, or strictly greater key (keeps stability)
  assign gt = !slot.valid || (slot.key > new_slot.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else if (ctrl.insert) begin
      if (gt) begin
        slot <= prev_gt ? prev_slot : new_slot;
      end
    end else if (ctrl.shift) begin
      slot <= next_slot;
    end
  end

endmodule

// ===== sv/iisk_chain.sv =====
// Row of insertion cells; the head cell presents the smallest key.
module iisk_chain
  import iisk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  chain_ctrl_t ctrl,
  input  slot_t       new_slot,
  output slot_t       head
);

  slot_t slots [MAX_RECORDS];
  logic  gts   [MAX_RECORDS];
  slot_t empty_slot;

  assign empty_slot = '{valid: 1'b0, key: '0, idx: '0};
  assign head       = slots[0];

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    slot_t prev_s;
    logic  prev_g;
    slot_t next_s;

    // Neighbor hookup; ends see an empty slot
    if (i == 0) begin : g_first
      assign prev_s = empty_slot;
      assign prev_g = 1'b0;
    end else begin : g_mid
      assign prev_s = slots[i-1];
      assign prev_g = gts[i-1];
    end
    if (i == MAX_RECORDS - 1) begin : g_last
      assign next_s = empty_slot;
    end else begin : g_nxt
      assign next_s = slots[i+1];
    end

    iisk_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .new_slot  (new_slot),
      .prev_slot (prev_s),
      .prev_gt   (prev_g),
      .next_slot (next_s),
      .slot      (slots[i]),
      .gt        (gts[i])
    );
  end

endmodule

// ===== sv/index_insertion_sort_two_keys_top.sv =====
// Top level: record capture, insertion-cell sort and sorted index drain.
//
//  channel   handshake          payload
//  input     start / busy       phone_number, age_years, is_last
//  config    cfg_we             cfg_data (sort_mode)
//  result    done (strobe)      record_index, overflowed, last_out
//
// Records are captured one per cycle into the key RAM while busy is low.
// Once the last record is taken, busy rises: the RAM is read out through the cell row,
// one insertion per cycle behind the registered RAM read, and once the last insertion
// has settled, the sorted indexes shift out of the head cell, one per cycle.
// Reset (rst, synchronous) empties the cells and clears count and overflow.
// Results are a one-cycle strobe; the receiver cannot stall them.
module index_insertion_sort_two_keys_top
  import iisk_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [PHONE_W-1:0] phone_number,
  input  logic [AGE_W-1:0]   age_years,
  input  logic               is_last,
  input  logic               cfg_we,
  input  logic               cfg_data,
  output logic               done,
  output logic [OIDX_W-1:0]  record_index,
  output logic               overflowed,
  output logic               last_out
);

  typedef enum logic [2:0] {
    ST_COLLECT = 3'b001,
    ST_LOAD    = 3'b010,
    ST_DRAIN   = 3'b100
  } state_t;

  state_t            state;
  logic              sort_mode;
  logic [CNT_W-1:0]  count;
  logic              overflow_flag;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  rd_ptr;
  logic              rd_vld;
  logic [OIDX_W-1:0] rd_idx;
  logic [CNT_W-1:0]  out_cnt;

  logic              accept;
  logic              has_room;
  logic              wr_en;
  logic [KEY_W-1:0]  rd_data;
  chain_ctrl_t       ctrl;
  slot_t             new_slot;
  slot_t             head;

  assign accept   = start && !busy;
  assign has_room = (count < CNT_W'(MAX_RECORDS));
  assign wr_en    = accept && has_room;
  assign busy     = (state != ST_COLLECT);

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      sort_mode <= MODE_AGE_PHONE;
    end else if (cfg_we) begin
      sort_mode <= cfg_data;
    end
  end

  // Key store, written in arrival order
  iisk_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_RECORDS)
  ) u_key_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[ADDR_W-1:0]),
    .wdata ({phone_number, age_years}),
    .raddr (rd_ptr[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  // Chain commands
  assign ctrl.insert     = (state == ST_LOAD) && rd_vld;
  assign ctrl.shift      = (state == ST_DRAIN);
  assign new_slot.valid  = 1'b1;
  assign new_slot.key    = sort_key(sort_mode, rd_data);
  assign new_slot.idx    = rd_idx;

  iisk_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .new_slot (new_slot),
    .head     (head)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_COLLECT;
      count         <= '0;
      overflow_flag <= 1'b0;
      rd_vld        <= 1'b0;
      rd_ptr        <= '0;
      total         <= '0;
      out_cnt       <= '0;
    end else begin
      case (state)
        ST_COLLECT: begin
          rd_vld <= 1'b0;
          rd_ptr <= '0;
          if (accept) begin
            if (has_room) begin
              count <= count + CNT_W'(1);
            end else begin
              overflow_flag <= 1'b1;
            end
            if (is_last) begin
              total <= has_room ? count + CNT_W'(1) : count;
              state <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          if (rd_ptr != total) begin
            rd_vld <= 1'b1;
            rd_idx <= OIDX_W'(rd_ptr);
            rd_ptr <= rd_ptr + CNT_W'(1);
          end else begin
            rd_vld <= 1'b0;
            if (!rd_vld) begin
              out_cnt <= total;
              state   <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          out_cnt <= out_cnt - CNT_W'(1);
          if (out_cnt == CNT_W'(1)) begin
            count         <= '0;
            overflow_flag <= 1'b0;
            state         <= ST_COLLECT;
          end
        end
        default: begin
          state <= ST_COLLECT;
        end
      endcase
    end
  end

  // Result strobe straight off the head cell
  assign done         = (state == ST_DRAIN);
  assign record_index = head.idx;
  assign overflowed   = overflow_flag;
  assign last_out     = (out_cnt == CNT_W'(1));

endmodule
